>>> rtl/triangle_face_normal_defines.svh
// Assertion macros used by the triangle face normal checker.
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define TFN_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define TFN_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tfn_pkg.sv
// Widths, stage counts and helpers for the triangle face normal pipeline.
package tfn_pkg;

    // Field widths
    localparam int COORD_W   = 16;
    localparam int OUT_W     = 16;

    // Datapath widths
    localparam int EDGE_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * EDGE_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int MAG_W     = 33;
    localparam int NORM_W    = 31;
    localparam int SQ_W      = 2 * NORM_W;
    localparam int SUM_W     = 64;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int SQREM_W   = ROOT_W + 1;
    localparam int TRIAL_W   = SQREM_W + 2;
    localparam int FRAC_BITS = 14;
    localparam int NUM_W     = NORM_W + FRAC_BITS + 1;
    localparam int QUO_W     = FRAC_BITS + 1;

    // Pipeline shape
    localparam int PRE_STAGES = 9;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int LATENCY    = PRE_STAGES + SQRT_STEPS + 1 + DIV_STEPS + 1;

    // Unit length in Q1.14
    localparam int UNIT_ONE = 1 << FRAC_BITS;
    localparam logic signed [OUT_W-1:0] NORMAL_MAX = OUT_W'(UNIT_ONE);
    localparam logic signed [OUT_W-1:0] NORMAL_MIN = -NORMAL_MAX;

    // Signed product of a pair of edge components
    function automatic logic signed [PROD_W-1:0] smul(
        input logic signed [EDGE_W-1:0] a,
        input logic signed [EDGE_W-1:0] b
    );
        return PROD_W'(a) * PROD_W'(b);
    endfunction

endpackage

>>> rtl/triangle_face_normal.sv
// Triangle face normal: edges, cross product, normalise to unit Q1.14.
//
// Input channel (s_valid/s_ready) takes one triangle per beat: three corners,
// each coordinate signed Q8.8. Result channel (m_valid/m_ready) gives one beat
// per triangle: signed Q1.14 unit normal of (second-first) x (third-first),
// each component in -16384..16384, and a degenerate flag. A zero cross
// product gives a zero normal with the flag set.
// An item passes the stages for edges, products, cross, magnitude and
// normalising shifts, squares and their sum, then the square root stages
// (one root bit per stage), a register for the rounding offset, the
// division stages (one quotient bit per stage) and the output register.
// Throughput is one triangle per cycle while the output is not stalled;
// the root and division stages are unrolled so every stage takes a new
// item each cycle. The whole pipeline advances together: when a result waits
// in the output register and m_ready is low, every stage holds and s_ready
// drops; empty stages do not block. Reset (aresetn low, synchronous) clears
// the valid bits only; in-flight items are dropped and no result is produced.
module triangle_face_normal
    import tfn_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_first_x,
    input  logic signed [COORD_W-1:0] s_first_y,
    input  logic signed [COORD_W-1:0] s_first_z,
    input  logic signed [COORD_W-1:0] s_second_x,
    input  logic signed [COORD_W-1:0] s_second_y,
    input  logic signed [COORD_W-1:0] s_second_z,
    input  logic signed [COORD_W-1:0] s_third_x,
    input  logic signed [COORD_W-1:0] s_third_y,
    input  logic signed [COORD_W-1:0] s_third_z,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [OUT_W-1:0]   m_normal_x,
    output logic signed [OUT_W-1:0]   m_normal_y,
    output logic signed [OUT_W-1:0]   m_normal_z,
    output logic                      m_degenerate
);

    logic               adv;
    logic [LATENCY-1:0] vld_reg;

    // Advance all stages unless the output beat is stalled
    assign adv     = m_ready || !m_valid;
    assign s_ready = adv;
    assign m_valid = vld_reg[LATENCY-1];

    // Carry valid bits alongside the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LATENCY-2:0], s_valid};
        end
    end

    // Stage 1: edge vectors
    logic signed [EDGE_W-1:0] u_next [3];
    logic signed [EDGE_W-1:0] v_next [3];
    logic signed [EDGE_W-1:0] u_reg  [3];
    logic signed [EDGE_W-1:0] v_reg  [3];

    always_comb begin
        u_next[0] = EDGE_W'(s_second_x) - EDGE_W'(s_first_x);
        u_next[1] = EDGE_W'(s_second_y) - EDGE_W'(s_first_y);
        u_next[2] = EDGE_W'(s_second_z) - EDGE_W'(s_first_z);
        v_next[0] = EDGE_W'(s_third_x) - EDGE_W'(s_first_x);
        v_next[1] = EDGE_W'(s_third_y) - EDGE_W'(s_first_y);
        v_next[2] = EDGE_W'(s_third_z) - EDGE_W'(s_first_z);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            u_reg <= u_next;
            v_reg <= v_next;
        end
    end

    // Stage 2: the six partial products of the cross product
    logic signed [PROD_W-1:0] prod_next [6];
    logic signed [PROD_W-1:0] prod_reg  [6];

    always_comb begin
        prod_next[0] = smul(u_reg[1], v_reg[2]);
        prod_next[1] = smul(u_reg[2], v_reg[1]);
        prod_next[2] = smul(u_reg[2], v_reg[0]);
        prod_next[3] = smul(u_reg[0], v_reg[2]);
        prod_next[4] = smul(u_reg[0], v_reg[1]);
        prod_next[5] = smul(u_reg[1], v_reg[0]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
        end
    end

    // Stage 3: cross product components
    logic signed [CROSS_W-1:0] cross_next [3];
    logic signed [CROSS_W-1:0] cross_reg  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cross_next[i] = CROSS_W'(prod_reg[2*i]) - CROSS_W'(prod_reg[2*i+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cross_reg <= cross_next;
        end
    end

    // Stage 4: split into sign and magnitude
    logic [MAG_W-1:0] mag_next [3];
    logic [MAG_W-1:0] mag_reg  [3];
    logic [2:0]       sgn4_next;
    logic [2:0]       sgn4_reg;

    always_comb begin
        logic [CROSS_W-1:0] abs_v;
        abs_v = '0;
        for (int i = 0; i < 3; i++) begin
            sgn4_next[i] = cross_reg[i][CROSS_W-1];
            abs_v = cross_reg[i][CROSS_W-1] ? CROSS_W'(-cross_reg[i])
                                            : CROSS_W'(cross_reg[i]);
            mag_next[i] = abs_v[MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_reg  <= mag_next;
            sgn4_reg <= sgn4_next;
        end
    end

    // Stage 5: right shift the largest magnitude into 31 bits, flag zero
    logic [MAG_W-1:0]  or5;
    logic [1:0]        rsh5;
    logic [NORM_W-1:0] nrm5_next [3];
    logic [NORM_W-1:0] nrm5_reg  [3];
    logic              dgn5_next;
    logic              dgn5_reg;
    logic [2:0]        sgn5_reg;

    always_comb begin
        or5       = mag_reg[0] | mag_reg[1] | mag_reg[2];
        dgn5_next = (or5 == '0);
        if (or5[MAG_W-1]) begin
            rsh5 = 2'd2;
        end else if (or5[MAG_W-2]) begin
            rsh5 = 2'd1;
        end else begin
            rsh5 = 2'd0;
        end
        for (int i = 0; i < 3; i++) begin
            nrm5_next[i] = NORM_W'(mag_reg[i] >> rsh5);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nrm5_reg <= nrm5_next;
            dgn5_reg <= dgn5_next;
            sgn5_reg <= sgn4_reg;
        end
    end

    // Stage 6: coarse left shifts by 16, 8 and 4
    logic [NORM_W-1:0] nrm6_next [3];
    logic [NORM_W-1:0] nrm6_reg  [3];
    logic              dgn6_reg;
    logic [2:0]        sgn6_reg;

    always_comb begin
        logic [NORM_W-1:0] o6;
        nrm6_next = nrm5_reg;
        o6 = nrm6_next[0] | nrm6_next[1] | nrm6_next[2];
        if (o6[NORM_W-1 -: 16] == '0) begin
            for (int i = 0; i < 3; i++) nrm6_next[i] = nrm6_next[i] << 16;
        end
        o6 = nrm6_next[0] | nrm6_next[1] | nrm6_next[2];
        if (o6[NORM_W-1 -: 8] == '0) begin
            for (int i = 0; i < 3; i++) nrm6_next[i] = nrm6_next[i] << 8;
        end
        o6 = nrm6_next[0] | nrm6_next[1] | nrm6_next[2];
        if (o6[NORM_W-1 -: 4] == '0) begin
            for (int i = 0; i < 3; i++) nrm6_next[i] = nrm6_next[i] << 4;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nrm6_reg <= nrm6_next;
            dgn6_reg <= dgn5_reg;
            sgn6_reg <= sgn5_reg;
        end
    end

    // Stage 7: fine left shifts by 2 and 1; top bit now at bit 30
    logic [NORM_W-1:0] nrm7_next [3];
    logic [NORM_W-1:0] nrm7_reg  [3];
    logic              dgn7_reg;
    logic [2:0]        sgn7_reg;

    always_comb begin
        logic [NORM_W-1:0] o7;
        nrm7_next = nrm6_reg;
        o7 = nrm7_next[0] | nrm7_next[1] | nrm7_next[2];
        if (o7[NORM_W-1 -: 2] == '0) begin
            for (int i = 0; i < 3; i++) nrm7_next[i] = nrm7_next[i] << 2;
        end
        o7 = nrm7_next[0] | nrm7_next[1] | nrm7_next[2];
        if (!o7[NORM_W-1]) begin
            for (int i = 0; i < 3; i++) nrm7_next[i] = nrm7_next[i] << 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nrm7_reg <= nrm7_next;
            dgn7_reg <= dgn6_reg;
            sgn7_reg <= sgn6_reg;
        end
    end

    // Stage 8: squares of the normalised magnitudes
    logic [SQ_W-1:0]   sq8_next [3];
    logic [SQ_W-1:0]   sq8_reg  [3];
    logic [NORM_W-1:0] nrm8_reg [3];
    logic              dgn8_reg;
    logic [2:0]        sgn8_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq8_next[i] = SQ_W'(nrm7_reg[i]) * SQ_W'(nrm7_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq8_reg  <= sq8_next;
            nrm8_reg <= nrm7_reg;
            dgn8_reg <= dgn7_reg;
            sgn8_reg <= sgn7_reg;
        end
    end

    // Square root pipeline; entry 0 is the sum of squares stage
    logic [SUM_W-1:0]   sqt_s_reg    [SQRT_STEPS+1];
    logic [SQREM_W-1:0] sqt_rem_reg  [SQRT_STEPS+1];
    logic [ROOT_W-1:0]  sqt_root_reg [SQRT_STEPS+1];
    logic [NORM_W-1:0]  sqt_nrm_reg  [SQRT_STEPS+1][3];
    logic [2:0]         sqt_sgn_reg  [SQRT_STEPS+1];
    logic               sqt_dgn_reg  [SQRT_STEPS+1];
    logic [SUM_W-1:0]   sum_next;

    // Stage 9: sum of squares
    assign sum_next = SUM_W'(sq8_reg[0]) + SUM_W'(sq8_reg[1]) + SUM_W'(sq8_reg[2]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqt_s_reg[0]    <= sum_next;
            sqt_rem_reg[0]  <= '0;
            sqt_root_reg[0] <= '0;
            sqt_nrm_reg[0]  <= nrm8_reg;
            sqt_sgn_reg[0]  <= sgn8_reg;
            sqt_dgn_reg[0]  <= dgn8_reg;
        end
    end

    // One root bit per stage, two radicand bits in from the top
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        logic [TRIAL_W-1:0] trial;
        logic [TRIAL_W-1:0] cand;
        logic               take;
        logic [SQREM_W-1:0] rem_next;
        logic [ROOT_W-1:0]  root_next;

        always_comb begin
            trial     = {sqt_rem_reg[j], sqt_s_reg[j][SUM_W-1-2*j -: 2]};
            cand      = TRIAL_W'({sqt_root_reg[j], 2'b01});
            take      = (trial >= cand);
            rem_next  = take ? SQREM_W'(trial - cand) : SQREM_W'(trial);
            root_next = {sqt_root_reg[j][ROOT_W-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sqt_s_reg[j+1]    <= sqt_s_reg[j];
                sqt_rem_reg[j+1]  <= rem_next;
                sqt_root_reg[j+1] <= root_next;
                sqt_nrm_reg[j+1]  <= sqt_nrm_reg[j];
                sqt_sgn_reg[j+1]  <= sqt_sgn_reg[j];
                sqt_dgn_reg[j+1]  <= sqt_dgn_reg[j];
            end
        end
    end

    // Division pipeline; entry 0 holds the rounded numerators
    logic [NUM_W-1:0]  div_rem_reg  [DIV_STEPS+1][3];
    logic [QUO_W-1:0]  div_q_reg    [DIV_STEPS+1][3];
    logic [ROOT_W-1:0] div_root_reg [DIV_STEPS+1];
    logic [2:0]        div_sgn_reg  [DIV_STEPS+1];
    logic              div_dgn_reg  [DIV_STEPS+1];
    logic [NUM_W-1:0]  num_next     [3];

    // Numerator: magnitude scaled by one unit plus half the root
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num_next[i] = NUM_W'({sqt_nrm_reg[SQRT_STEPS][i], {FRAC_BITS{1'b0}}})
                        + NUM_W'(sqt_root_reg[SQRT_STEPS] >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            div_rem_reg[0]  <= num_next;
            div_q_reg[0]    <= '{default: '0};
            div_root_reg[0] <= sqt_root_reg[SQRT_STEPS];
            div_sgn_reg[0]  <= sqt_sgn_reg[SQRT_STEPS];
            div_dgn_reg[0]  <= sqt_dgn_reg[SQRT_STEPS];
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int QB = DIV_STEPS - 1 - j;
        logic [NUM_W-1:0] dvs;
        logic [NUM_W-1:0] rem_next [3];
        logic [QUO_W-1:0] q_next   [3];

        always_comb begin
            dvs = NUM_W'(div_root_reg[j]) << QB;
            for (int i = 0; i < 3; i++) begin
                q_next[i] = div_q_reg[j][i];
                if (div_rem_reg[j][i] >= dvs) begin
                    rem_next[i]   = div_rem_reg[j][i] - dvs;
                    q_next[i][QB] = 1'b1;
                end else begin
                    rem_next[i] = div_rem_reg[j][i];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                div_rem_reg[j+1]  <= rem_next;
                div_q_reg[j+1]    <= q_next;
                div_root_reg[j+1] <= div_root_reg[j];
                div_sgn_reg[j+1]  <= div_sgn_reg[j];
                div_dgn_reg[j+1]  <= div_dgn_reg[j];
            end
        end
    end

    // Output stage: apply signs, zero the normal of a degenerate triangle
    logic signed [OUT_W-1:0] nout_next [3];
    logic signed [OUT_W-1:0] nout_reg  [3];
    logic                    dgn_out_reg;

    always_comb begin
        logic signed [OUT_W-1:0] q16;
        q16 = '0;
        for (int i = 0; i < 3; i++) begin
            q16 = OUT_W'(div_q_reg[DIV_STEPS][i]);
            if (div_dgn_reg[DIV_STEPS]) begin
                nout_next[i] = '0;
            end else if (div_sgn_reg[DIV_STEPS][i]) begin
                nout_next[i] = -q16;
            end else begin
                nout_next[i] = q16;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nout_reg    <= nout_next;
            dgn_out_reg <= div_dgn_reg[DIV_STEPS];
        end
    end

    assign m_normal_x   = nout_reg[0];
    assign m_normal_y   = nout_reg[1];
    assign m_normal_z   = nout_reg[2];
    assign m_degenerate = dgn_out_reg;

endmodule

>>> rtl/tfn_checker.sv
// Port-level checker for the triangle face normal, bound to the top level.
`include "triangle_face_normal_defines.svh"

module tfn_checker
    import tfn_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [OUT_W-1:0] m_normal_x,
    input logic signed [OUT_W-1:0] m_normal_y,
    input logic signed [OUT_W-1:0] m_normal_z,
    input logic                    m_degenerate
);

    // Hold a stalled result beat
    `TFN_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_normal_x) && $stable(m_normal_y) && $stable(m_normal_z) && $stable(m_degenerate), "stalled result beat changed")

    // Drop input ready while a result beat is stalled
    `TFN_ASSERT_SAME(a_stall_backpressure, aclk, aresetn, m_valid && !m_ready, !s_ready, "input ready while output stalled")

    // Degenerate beats carry a zero normal
    `TFN_ASSERT_SAME(a_degenerate_zero, aclk, aresetn, m_valid && m_degenerate, m_normal_x == '0 && m_normal_y == '0 && m_normal_z == '0, "degenerate beat with nonzero normal")

    // Non-degenerate beats carry a nonzero normal
    `TFN_ASSERT_SAME(a_normal_nonzero, aclk, aresetn, m_valid && !m_degenerate, m_normal_x != '0 || m_normal_y != '0 || m_normal_z != '0, "zero normal without degenerate flag")

    // Keep each component within unit range
    `TFN_ASSERT_SAME(a_unit_range, aclk, aresetn, m_valid, m_normal_x >= NORMAL_MIN && m_normal_x <= NORMAL_MAX && m_normal_y >= NORMAL_MIN && m_normal_y <= NORMAL_MAX && m_normal_z >= NORMAL_MIN && m_normal_z <= NORMAL_MAX, "normal component out of range")

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (.*);
